### rtl/core/hierarchical_depth_pyramid_top_macros.svh
// Assertion macros for the hierarchical depth pyramid block.
// Included by the modules that carry concurrent assertions.
`ifndef HIERARCHICAL_DEPTH_PYRAMID_TOP_MACROS_SVH
`define HIERARCHICAL_DEPTH_PYRAMID_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HDP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hdp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hdp assertion failed");

`endif

### rtl/core/hdp_pkg.sv
// Package for the hierarchical depth pyramid: sizes, level table and
// the request/response structs shared by the core modules. No dependencies.
package hdp_pkg;

    localparam int SIDE        = 256;
    localparam int SIDE_BITS   = 8;
    localparam int DEPTH_BITS  = 24;
    localparam int COLOR_BITS  = 24;
    localparam int LEVELS      = 9;
    localparam int LVL_BITS    = 4;
    localparam int PYR_TOTAL   = 87381;
    localparam int ADDR_BITS   = 17;
    localparam int COORD_BITS  = SIDE_BITS + 2;
    localparam int SUB_BITS    = 3;

    localparam logic [ADDR_BITS-1:0] LVL_BASE [LEVELS] = '{
        17'd0, 17'd65536, 17'd81920, 17'd86016, 17'd87040,
        17'd87296, 17'd87360, 17'd87376, 17'd87380
    };

    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [DEPTH_BITS-1:0] t_depth;

    typedef struct packed {
        logic   we;
        t_addr  addr;
        t_depth wdata;
    } t_mem_req;

    typedef struct packed {
        t_depth a;
        t_depth b;
    } t_cmp_req;

    typedef struct packed {
        logic   lt;
        t_depth min;
    } t_cmp_res;

endpackage

### rtl/core/hdp_depth_mem.sv
// Depth pyramid storage: single-port memory, one access per cycle,
// registered read data. Depends on hdp_pkg.
module hdp_depth_mem
    import hdp_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_depth   o_rdata
);

    t_depth r_mem [PYR_TOTAL];
    t_depth r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/hdp_cmp_unit.sv
// Shared depth comparator: less-than flag and minimum of two depths.
// Depends on hdp_pkg.
module hdp_cmp_unit
    import hdp_pkg::*;
(
    input  t_cmp_req i_req,
    output t_cmp_res o_res
);

    always_comb begin
        o_res.lt  = i_req.a < i_req.b;
        o_res.min = o_res.lt ? i_req.a : i_req.b;
    end

endmodule

### rtl/core/hdp_ctrl.sv
// Sequencer for the depth pyramid: memory clear, box query descent and
// pixel write with level rebuild. Depends on hdp_pkg and the macro header.
`include "hierarchical_depth_pyramid_top_macros.svh"

module hdp_ctrl
    import hdp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_opcode,
    input  logic [SIDE_BITS-1:0]  i_box_x_max,
    input  logic [SIDE_BITS-1:0]  i_box_x_min,
    input  logic [SIDE_BITS-1:0]  i_box_y_max,
    input  logic [SIDE_BITS-1:0]  i_box_y_min,
    input  t_depth                i_depth,
    input  logic [SIDE_BITS-1:0]  i_pixel_x,
    input  logic [SIDE_BITS-1:0]  i_pixel_y,
    input  logic [COLOR_BITS-1:0] i_pixel_color,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_visible,
    output logic                  o_write_enable,
    output logic [SIDE_BITS-1:0]  o_write_x,
    output logic [SIDE_BITS-1:0]  o_write_y,
    output logic [COLOR_BITS-1:0] o_write_color,
    output t_mem_req              o_mem_req,
    input  t_depth                i_mem_rdata,
    output t_cmp_req              o_cmp_req,
    input  t_cmp_res              i_cmp_res
);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [LVL_BITS-1:0]          t_lvl;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_QX    = 11'b000_0000_0100,
        S_QY    = 11'b000_0000_1000,
        S_QADJ  = 11'b000_0001_0000,
        S_QRD   = 11'b000_0010_0000,
        S_QCMP  = 11'b000_0100_0000,
        S_WRD   = 11'b000_1000_0000,
        S_WTEST = 11'b001_0000_0000,
        S_RRD   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    localparam t_lvl                SB_L     = t_lvl'(SIDE_BITS);
    localparam t_lvl                LVL_LAST = t_lvl'(LEVELS - 1);
    localparam logic [SUB_BITS-1:0] SUB_LAST = SUB_BITS'(4);
    localparam t_addr               CLR_LAST = t_addr'(PYR_TOTAL - 1);

    function automatic t_coord halve(input t_coord v);
        t_coord t;
        t = v + t_coord'({{(COORD_BITS-1){1'b0}}, v[COORD_BITS-1]});
        return t >>> 1;
    endfunction

    t_state                r_state, n_state;
    t_addr                 r_clr_addr, n_clr_addr;
    t_coord                r_xa, n_xa, r_xb, n_xb, r_ya, n_ya, r_yb, n_yb;
    t_lvl                  r_hx, n_hx, r_hy, n_hy;
    t_depth                r_depth, n_depth;
    logic [SIDE_BITS-1:0]  r_px, n_px, r_py, n_py, r_cx, n_cx, r_cy, n_cy;
    logic [COLOR_BITS-1:0] r_color, n_color;
    t_lvl                  r_lvl, n_lvl;
    logic [SUB_BITS-1:0]   r_sub, n_sub;
    t_depth                r_acc, n_acc;
    logic                  r_res_vis, n_res_vis, r_res_we, n_res_we;
    logic [SIDE_BITS-1:0]  r_res_x, n_res_x, r_res_y, n_res_y;
    logic [COLOR_BITS-1:0] r_res_col, n_res_col;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_vis, n_out_vis, r_out_we, n_out_we;
    logic [SIDE_BITS-1:0]  r_out_x, n_out_x, r_out_y, n_out_y;
    logic [COLOR_BITS-1:0] r_out_col, n_out_col;

    t_coord w_qlen;
    logic   w_qroot;
    t_lvl   w_qlvl;
    t_addr  w_qaddr;
    t_addr  w_l0addr;
    t_lvl   w_clvl;
    t_addr  w_child_addr;
    t_addr  w_parent_addr;

    always_comb begin
        w_qlen  = $signed(COORD_BITS'(SIDE) >> r_hx);
        w_qroot = (r_hx >= t_lvl'(LEVELS)) || (r_xa < 0) || (r_ya < 0) ||
                  (r_xa >= w_qlen) || (r_ya >= w_qlen);
        w_qlvl  = w_qroot ? LVL_LAST : r_hx;
        w_qaddr = LVL_BASE[w_qlvl] + (w_qroot ? t_addr'(0) :
                  ((t_addr'(r_ya[SIDE_BITS-1:0]) << (SB_L - r_hx)) +
                   t_addr'(r_xa[SIDE_BITS-1:0])));

        w_l0addr = t_addr'({r_py, r_px});

        w_clvl        = r_lvl - t_lvl'(1);
        w_child_addr  = LVL_BASE[w_clvl] +
                        (t_addr'({r_cy[SIDE_BITS-1:1], r_sub[1]}) << (SB_L - w_clvl)) +
                        t_addr'({r_cx[SIDE_BITS-1:1], r_sub[0]});
        w_parent_addr = LVL_BASE[r_lvl] +
                        (t_addr'(r_cy >> 1) << (SB_L - r_lvl)) +
                        t_addr'(r_cx >> 1);
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_xa        = r_xa;
        n_xb        = r_xb;
        n_ya        = r_ya;
        n_yb        = r_yb;
        n_hx        = r_hx;
        n_hy        = r_hy;
        n_depth     = r_depth;
        n_px        = r_px;
        n_py        = r_py;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_color     = r_color;
        n_lvl       = r_lvl;
        n_sub       = r_sub;
        n_acc       = r_acc;
        n_res_vis   = r_res_vis;
        n_res_we    = r_res_we;
        n_res_x     = r_res_x;
        n_res_y     = r_res_y;
        n_res_col   = r_res_col;
        n_out_valid = r_out_valid;
        n_out_vis   = r_out_vis;
        n_out_we    = r_out_we;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_col   = r_out_col;

        o_mem_req.we    = 1'b0;
        o_mem_req.addr  = w_l0addr;
        o_mem_req.wdata = r_depth;
        o_cmp_req.a     = i_mem_rdata;
        o_cmp_req.b     = r_depth;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.addr  = r_clr_addr;
                o_mem_req.wdata = '0;
                n_clr_addr      = r_clr_addr + t_addr'(1);
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_depth = i_depth;
                    n_xa    = $signed({2'b00, i_box_x_max}) - $signed(COORD_BITS'(1));
                    n_xb    = $signed({2'b00, i_box_x_min}) + $signed(COORD_BITS'(1));
                    n_ya    = $signed({2'b00, i_box_y_max}) - $signed(COORD_BITS'(1));
                    n_yb    = $signed({2'b00, i_box_y_min}) + $signed(COORD_BITS'(1));
                    n_hx    = '0;
                    n_hy    = '0;
                    n_px    = i_pixel_x;
                    n_py    = i_pixel_y;
                    n_color = i_pixel_color;
                    n_state = i_opcode ? S_WRD : S_QX;
                end
            end
            S_QX: begin
                if (r_xa != r_xb) begin
                    n_xa = halve(r_xa);
                    n_xb = halve(r_xb);
                    n_hx = r_hx + t_lvl'(1);
                end else begin
                    n_state = S_QY;
                end
            end
            S_QY: begin
                if (r_ya != r_yb) begin
                    n_ya = halve(r_ya);
                    n_yb = halve(r_yb);
                    n_hy = r_hy + t_lvl'(1);
                end else begin
                    n_state = S_QADJ;
                end
            end
            S_QADJ: begin
                if (r_hx > r_hy) begin
                    n_ya = halve(r_ya);
                    n_hy = r_hy + t_lvl'(1);
                end else if (r_hy > r_hx) begin
                    n_xa = halve(r_xa);
                    n_hx = r_hx + t_lvl'(1);
                end else begin
                    n_state = S_QRD;
                end
            end
            S_QRD: begin
                o_mem_req.addr = w_qaddr;
                n_state        = S_QCMP;
            end
            S_QCMP: begin
                n_res_vis = i_cmp_res.lt;
                n_res_we  = 1'b0;
                n_res_x   = '0;
                n_res_y   = '0;
                n_res_col = '0;
                n_state   = S_DONE;
            end
            S_WRD: begin
                n_state = S_WTEST;
            end
            S_WTEST: begin
                if (i_cmp_res.lt) begin
                    o_mem_req.we = 1'b1;
                    n_res_vis    = 1'b1;
                    n_res_we     = 1'b1;
                    n_res_x      = r_px;
                    n_res_y      = r_py;
                    n_res_col    = r_color;
                    n_lvl        = t_lvl'(1);
                    n_sub        = '0;
                    n_cx         = r_px;
                    n_cy         = r_py;
                    n_state      = S_RRD;
                end else begin
                    n_res_vis = 1'b0;
                    n_res_we  = 1'b0;
                    n_res_x   = '0;
                    n_res_y   = '0;
                    n_res_col = '0;
                    n_state   = S_DONE;
                end
            end
            S_RRD: begin
                o_cmp_req.a    = (r_sub == SUB_BITS'(1)) ? '1 : r_acc;
                o_cmp_req.b    = i_mem_rdata;
                o_mem_req.addr = (r_sub == SUB_LAST) ? w_parent_addr : w_child_addr;
                if (r_sub != '0) begin
                    n_acc = i_cmp_res.min;
                end
                if (r_sub == SUB_LAST) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.wdata = i_cmp_res.min;
                    n_cx            = r_cx >> 1;
                    n_cy            = r_cy >> 1;
                    n_sub           = '0;
                    if (r_lvl == LVL_LAST) begin
                        n_state = S_DONE;
                    end else begin
                        n_lvl = r_lvl + t_lvl'(1);
                    end
                end else begin
                    n_sub = r_sub + SUB_BITS'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_vis   = r_res_vis;
                    n_out_we    = r_res_we;
                    n_out_x     = r_res_x;
                    n_out_y     = r_res_y;
                    n_out_col   = r_res_col;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_lvl       <= '0;
            r_sub       <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_lvl       <= n_lvl;
            r_sub       <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xa      <= n_xa;
        r_xb      <= n_xb;
        r_ya      <= n_ya;
        r_yb      <= n_yb;
        r_hx      <= n_hx;
        r_hy      <= n_hy;
        r_depth   <= n_depth;
        r_px      <= n_px;
        r_py      <= n_py;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_color   <= n_color;
        r_acc     <= n_acc;
        r_res_vis <= n_res_vis;
        r_res_we  <= n_res_we;
        r_res_x   <= n_res_x;
        r_res_y   <= n_res_y;
        r_res_col <= n_res_col;
        r_out_vis <= n_out_vis;
        r_out_we  <= n_out_we;
        r_out_x   <= n_out_x;
        r_out_y   <= n_out_y;
        r_out_col <= n_out_col;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_visible      = r_out_vis;
    assign o_write_enable = r_out_we;
    assign o_write_x      = r_out_x;
    assign o_write_y      = r_out_y;
    assign o_write_color  = r_out_col;

    `HDP_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_valid && o_ready, r_state != S_IDLE)
    `HDP_ASSERT_NOW(a_query_levels_agree, i_clk, i_rst_n, r_state == S_QRD, r_hx == r_hy)
    `HDP_ASSERT_NEXT(a_rebuild_ends_done, i_clk, i_rst_n, (r_state == S_RRD) && (r_sub == SUB_LAST) && (r_lvl == LVL_LAST), r_state == S_DONE)
    `HDP_ASSERT_NOW(a_write_implies_pass, i_clk, i_rst_n, r_out_valid && r_out_we, r_out_vis)

endmodule

### rtl/core/hierarchical_depth_pyramid_top.sv
// Top level of the hierarchical depth pyramid block.
// Depends on hdp_pkg, hdp_depth_mem, hdp_cmp_unit and hdp_ctrl.
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_ready  opcode, box, depth, pixel, color
//   result    out        o_valid / i_ready  visible, write enable, x, y, color
//
// After reset the pyramid memory is swept to zero, one entry a cycle, over
// all 87381 entries; o_ready stays low meanwhile.
// A query halves the box in x, then in y, aligns the two levels, then reads
// one pyramid entry and compares it; each halving is a separate step.
// A rejected pixel write ends after its depth test; a passing one rebuilds
// eight levels of four child reads and one parent write on the single port.
// A finished result waits in the output register while the next request
// is taken; a stalled output only holds the sequencer at its final step.
module hierarchical_depth_pyramid_top
    import hdp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_opcode,
    input  logic [SIDE_BITS-1:0]  i_box_x_max,
    input  logic [SIDE_BITS-1:0]  i_box_x_min,
    input  logic [SIDE_BITS-1:0]  i_box_y_max,
    input  logic [SIDE_BITS-1:0]  i_box_y_min,
    input  logic [DEPTH_BITS-1:0] i_depth,
    input  logic [SIDE_BITS-1:0]  i_pixel_x,
    input  logic [SIDE_BITS-1:0]  i_pixel_y,
    input  logic [COLOR_BITS-1:0] i_pixel_color,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_visible,
    output logic                  o_write_enable,
    output logic [SIDE_BITS-1:0]  o_write_x,
    output logic [SIDE_BITS-1:0]  o_write_y,
    output logic [COLOR_BITS-1:0] o_write_color
);

    t_mem_req mem_req;
    t_depth   mem_rdata;
    t_cmp_req cmp_req;
    t_cmp_res cmp_res;

    hdp_depth_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    hdp_cmp_unit u_cmp (
        .i_req (cmp_req),
        .o_res (cmp_res)
    );

    hdp_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_box_x_max    (i_box_x_max),
        .i_box_x_min    (i_box_x_min),
        .i_box_y_max    (i_box_y_max),
        .i_box_y_min    (i_box_y_min),
        .i_depth        (i_depth),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_pixel_color  (i_pixel_color),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_visible      (o_visible),
        .o_write_enable (o_write_enable),
        .o_write_x      (o_write_x),
        .o_write_y      (o_write_y),
        .o_write_color  (o_write_color),
        .o_mem_req      (mem_req),
        .i_mem_rdata    (mem_rdata),
        .o_cmp_req      (cmp_req),
        .i_cmp_res      (cmp_res)
    );

endmodule
